// ===== src/frb_pkg.sv =====
// Shared types and codes for the frame ring buffer.
// No dependencies.
`timescale 1ns / 1ps
package frb_pkg;

  localparam int unsigned StoreBytesDef = 65536;
  localparam int unsigned MaxFramesDef  = 256;
  localparam int unsigned SizeW = 17;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DROP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_BIG   = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DESC_FULL = 3'd4
  } status_e;

  // back end sequencing: memory read cycle, then execute cycle
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         data_byte;
    logic [SizeW-1:0]   frame_size;
    logic [7:0]         frame_kind;
    logic signed [63:0] present_time;
    logic signed [63:0] decode_time;
  } item_t;

  typedef struct packed {
    logic [SizeW-1:0]   size;
    logic [7:0]         kind;
    logic signed [63:0] present_time;
    logic signed [63:0] decode_time;
  } desc_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         out_byte;
    logic [SizeW-1:0]   out_size;
    logic [7:0]         out_kind;
    logic signed [63:0] out_present_time;
    logic signed [63:0] out_decode_time;
    logic               end_of_frame;
    logic [8:0]         frames_queued;
    logic [SizeW-1:0]   free_bytes;
  } result_t;

endpackage

// ===== src/frb_front.sv =====
// Front end: accepts input words and queues them.
// Depends on frb_pkg.
`timescale 1ns / 1ps
module frb_front import frb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  logic  q_pop_i
);

  item_t      slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !q_pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> (cnt_q == 2'd2))
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q == rd_q) |-> (cnt_q == 2'd0 || cnt_q == 2'd2))
    else $error("queue pointers disagree with count");

endmodule

// ===== src/frb_back.sv =====
// Back end: byte ring, descriptor FIFO and result register.
// Depends on frb_pkg.
`timescale 1ns / 1ps
module frb_back import frb_pkg::*; #(
  parameter int unsigned StoreBytes = StoreBytesDef,
  parameter int unsigned MaxFrames  = MaxFramesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  localparam int unsigned PW = $clog2(StoreBytes);
  localparam int unsigned SW = ((PW > SizeW) ? PW : SizeW) + 1;
  localparam int unsigned FW = $clog2(MaxFrames);
  localparam int unsigned CW = $clog2(MaxFrames + 1);

  logic [7:0] byte_mem [StoreBytes];
  desc_t      desc_mem [MaxFrames];
  logic [7:0] byte_rd_q;
  desc_t      desc_rd_q;

  state_e state_q, state_d;
  logic [SizeW-1:0] capreg_q;
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [SW-1:0]    held_q, held_d;
  logic [FW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SizeW-1:0] wo_q, wo_d, ro_q, ro_d;
  logic             drop_q, drop_d;
  result_t          res_q, res_d;
  logic             resv_q, resv_d;

  logic [SW-1:0]    cap, fs, rem;
  logic             out_free, skip, pop, byte_we, desc_we;
  logic [PW-1:0]    byte_wa;
  logic [FW-1:0]    desc_wa;

  function automatic logic [PW-1:0] wrap_add(logic [SW-1:0] p, logic [SW-1:0] n,
                                             logic [SW-1:0] c);
    logic [SW-1:0] s;
    s = p + n;
    if (s >= c) s = s - c;
    return s[PW-1:0];
  endfunction

  function automatic logic [FW-1:0] next_slot(logic [FW-1:0] i);
    return (i == FW'(MaxFrames - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    if (capreg_q == '0) cap = SW'(1);
    else if (SW'(capreg_q) > SW'(StoreBytes)) cap = SW'(StoreBytes);
    else cap = SW'(capreg_q);
  end

  assign out_free    = !resv_q || res_ready_i;
  assign res_valid_o = resv_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    wp_d = wp_q; rp_d = rp_q; held_d = held_q;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q;
    wo_d = wo_q; ro_d = ro_q; drop_d = drop_q;
    res_d = res_q;
    resv_d = resv_q && !res_ready_i;
    q_pop_o = 1'b0;
    byte_we = 1'b0; byte_wa = wp_q;
    desc_we = 1'b0; desc_wa = tail_q;
    skip = 1'b0; pop = 1'b0;
    fs = SW'(q_item_i.frame_size);
    rem = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          q_pop_o = 1'b1;
          state_d = S_IDLE;
          res_d = '0;
          res_d.status = ST_OK;
          unique case (q_item_i.op)
            OP_WRITE: begin
              if (wo_q == '0) begin
                drop_d = 1'b0;
                if (fs == '0) begin
                  skip = 1'b1;
                end else if (fs > cap) begin
                  res_d.status = ST_TOO_BIG; drop_d = 1'b1;
                end else if (cnt_q >= CW'(MaxFrames)) begin
                  res_d.status = ST_DESC_FULL; drop_d = 1'b1;
                end else if (cap - held_q < fs) begin
                  res_d.status = ST_NO_ROOM; drop_d = 1'b1;
                end
              end else if (drop_q) begin
                res_d.status = ST_NO_ROOM;
              end else if (held_q >= cap) begin
                // ring full mid-frame: take back the partial frame
                wp_d = wrap_add(SW'(wp_q), cap - SW'(wo_q), cap);
                held_d = held_q - SW'(wo_q);
                drop_d = 1'b1;
                res_d.status = ST_NO_ROOM;
              end
              if (!skip) begin
                if (!drop_d) begin
                  byte_we = 1'b1;
                  wp_d = wrap_add(SW'(wp_q), SW'(1), cap);
                  held_d = held_q + 1'b1;
                end
                wo_d = wo_q + 1'b1;
                if (SW'(wo_d) >= fs) begin
                  if (!drop_d) begin
                    desc_we = 1'b1;
                    tail_d = next_slot(tail_q);
                    cnt_d = cnt_q + 1'b1;
                  end
                  wo_d = '0;
                  drop_d = 1'b0;
                end
              end
            end
            OP_READ, OP_DROP: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                res_d.out_size = desc_rd_q.size;
                res_d.out_kind = desc_rd_q.kind;
                res_d.out_present_time = desc_rd_q.present_time;
                res_d.out_decode_time = desc_rd_q.decode_time;
                if (q_item_i.op == OP_READ) begin
                  res_d.out_byte = byte_rd_q;
                  rp_d = wrap_add(SW'(rp_q), SW'(1), cap);
                  if (held_q != '0) held_d = held_q - 1'b1;
                  ro_d = ro_q + 1'b1;
                  pop = (ro_d >= desc_rd_q.size);
                  res_d.end_of_frame = pop;
                end else begin
                  rem = (desc_rd_q.size > ro_q) ? SW'(desc_rd_q.size - ro_q) : '0;
                  if (rem > held_q) rem = held_q;
                  rp_d = wrap_add(SW'(rp_q), rem, cap);
                  held_d = held_q - rem;
                  pop = 1'b1;
                end
                if (pop) begin
                  head_d = next_slot(head_q);
                  cnt_d = cnt_q - 1'b1;
                  ro_d = '0;
                end
              end
            end
            OP_CLEAR: begin
              wp_d = '0; rp_d = '0; held_d = '0;
              head_d = '0; tail_d = '0; cnt_d = '0;
              wo_d = '0; ro_d = '0; drop_d = 1'b0;
            end
            default: ;
          endcase
          res_d.frames_queued = 9'(cnt_d);
          res_d.free_bytes = SizeW'(cap - held_d);
          resv_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      capreg_q <= SizeW'(65536);
      wp_q <= '0; rp_q <= '0; held_q <= '0;
      head_q <= '0; tail_q <= '0; cnt_q <= '0;
      wo_q <= '0; ro_q <= '0; drop_q <= 1'b0;
      resv_q <= 1'b0;
    end else if (cfg_we_i) begin
      // capacity write also empties the ring
      capreg_q <= cfg_data_i;
      wp_q <= '0; rp_q <= '0; held_q <= '0;
      head_q <= '0; tail_q <= '0; cnt_q <= '0;
      wo_q <= '0; ro_q <= '0; drop_q <= 1'b0;
      state_q <= state_d;
      resv_q <= resv_d;
    end else begin
      state_q <= state_d;
      wp_q <= wp_d; rp_q <= rp_d; held_q <= held_d;
      head_q <= head_d; tail_q <= tail_d; cnt_q <= cnt_d;
      wo_q <= wo_d; ro_q <= ro_d; drop_q <= drop_d;
      resv_q <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_wa] <= q_item_i.data_byte;
    if (state_q == S_IDLE) byte_rd_q <= byte_mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= '{size: wo_q + 1'b1, kind: q_item_i.frame_kind,
                             present_time: q_item_i.present_time,
                             decode_time: q_item_i.decode_time};
    end
    if (state_q == S_IDLE) desc_rd_q <= desc_mem[head_q];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= cap)
    else $error("bytes held exceed capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxFrames))
    else $error("descriptor count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (ro_q == '0))
    else $error("read offset without a queued frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !out_free && !cfg_we_i) |=> (state_q == S_EXEC))
    else $error("item retired while result register busy");

endmodule

// ===== src/frame_ring_buffer_core.sv =====
// Frame ring buffer top level: stream ports, word packing.
// Depends on frb_pkg, frb_front, frb_back.
// With an empty queue and a free output, an accepted word passes the memory read
// state and then the execute state; its result is registered on the same edge
// that it leaves the input queue. The back end finishes each word before the next.
// A 2-word input queue and the result register let both sides stall apart.
// Reset: pointers, counts and queues clear at once; capacity resets to 65536.
`timescale 1ns / 1ps
module frame_ring_buffer_core import frb_pkg::*; #(
  parameter int unsigned StoreBytes = StoreBytesDef,
  parameter int unsigned MaxFrames  = MaxFramesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [16:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_byte[7:0] frame_size[24:8] frame_kind[32:25] present_time[96:33]
  // decode_time[160:97], zero pad above
  input  logic [167:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte[7:0] out_size[24:8] out_kind[32:25] out_present_time[96:33]
  // out_decode_time[160:97] frames_queued[169:161] free_bytes[186:170], zero pad
  output logic [191:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser,
  // end_of_frame
  output logic         m_axis_tlast
);

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  always_comb begin
    in_item.op           = op_e'(s_axis_tuser);
    in_item.data_byte    = s_axis_tdata[7:0];
    in_item.frame_size   = s_axis_tdata[24:8];
    in_item.frame_kind   = s_axis_tdata[32:25];
    in_item.present_time = s_axis_tdata[96:33];
    in_item.decode_time  = s_axis_tdata[160:97];
  end

  frb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  frb_back #(.StoreBytes(StoreBytes), .MaxFrames(MaxFrames)) u_back (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.free_bytes, res.frames_queued, res.out_decode_time,
                         res.out_present_time, res.out_kind, res.out_size, res.out_byte};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.end_of_frame;

endmodule
